/* rtl/scl_pkg.sv */
// Package for the stereo soft-clip limiter: payload and register types, fixed-point
// constants and pipeline depths.
// Depends on nothing; every other file in rtl uses it.
package scl_pkg;

	localparam int SAMPLE_BITS = 24;

	// Scaled magnitude after the makeup gain, unsigned Q.23, always below 2^28.
	localparam int A_W        = 28;
	localparam int GAIN_SHIFT = SAMPLE_BITS - 5;
	localparam int UP         = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
	localparam int DN         = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;

	localparam int SQ_STEPS = 16;
	localparam int N_TERMS  = 12;
	localparam int LOG_LAT  = SQ_STEPS + 2;
	localparam int EXP_LAT  = 3 * N_TERMS + 1;
	localparam int CH_LAT   = 2 + LOG_LAT + 4 + EXP_LAT + 4;
	localparam int SIDE_DLY = CH_LAT - 5;

	localparam logic signed [21:0] K1_Q16     = 22'sd821238;
	localparam logic signed [31:0] LOG2E_Q30  = 32'sd1549082005;
	localparam logic [29:0]        LN2_Q30    = 30'd744261118;
	localparam logic [19:0]        DB2LOG_Q23 = 20'd965774;
	localparam logic [30:0]        Q30_ONE    = 31'h4000_0000;
	localparam logic [30:0]        R_CAP      = 31'h4000_0000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CDB     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KNEE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE   = 3'd4;

	typedef logic [SAMPLE_BITS-1:0] smag_t;
	typedef logic [SAMPLE_BITS+23:0] gprod_t;
	typedef logic [A_W-1:0] amag_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} out_t;

	typedef struct packed {
		logic [23:0]        gain;
		logic [23:0]        ceiling;
		logic signed [13:0] cdb;
		logic [23:0]        knee;
		logic [18:0]        slope;
	} cfg_t;

endpackage

/* rtl/scl_log2.sv */
// Pipelined base-2 logarithm of the scaled magnitude: leading-one search,
// normalization and one mantissa squaring per stage.
// Depends on scl_pkg.
module scl_log2 (
	input  logic                     clk,
	input  logic [scl_pkg::A_W-1:0] a,
	output logic [4:0]               pos,
	output logic [15:0]              frac
);

	logic [4:0]                lead;
	logic [4:0]                pos_s1;
	logic [scl_pkg::A_W-1:0]   a_s1;
	logic [58:0]               norm;
	logic [4:0]                pos_s [scl_pkg::SQ_STEPS+1];
	logic [30:0]               mant_s [scl_pkg::SQ_STEPS+1];
	logic [15:0]               frac_s [scl_pkg::SQ_STEPS+1];

	always_comb begin
		lead = '0;
		for (int i = 0; i < scl_pkg::A_W; i++) begin
			if (a[i]) lead = 5'(i);
		end
	end

	assign norm = 59'(a_s1) << (5'd30 - pos_s1);

	always_ff @(posedge clk) begin
		pos_s1    <= lead;
		a_s1      <= a;
		pos_s[0]  <= pos_s1;
		mant_s[0] <= norm[30:0];
		frac_s[0] <= '0;
	end

	// Each squaring doubles the exponent; a carry past 2.0 yields the next fraction bit.
	for (genvar j = 0; j < scl_pkg::SQ_STEPS; j++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] sr;
		assign sq = 62'(mant_s[j]) * 62'(mant_s[j]);
		assign sr = sq[61:30];
		always_ff @(posedge clk) begin
			mant_s[j+1] <= sr[31] ? sr[31:1] : sr[30:0];
			frac_s[j+1] <= {frac_s[j][14:0], sr[31]};
			pos_s[j+1]  <= pos_s[j];
		end
	end

	assign pos  = pos_s[scl_pkg::SQ_STEPS];
	assign frac = frac_s[scl_pkg::SQ_STEPS];

endmodule

/* rtl/scl_exp2.sv */
// Pipelined 2^f for a 16-bit fraction f: a truncated Taylor series of exp(f*ln2),
// three stages per term (multiply, reciprocal divide, correct and accumulate).
// Depends on scl_pkg.
module scl_exp2 (
	input  logic        clk,
	input  logic [15:0] uf,
	output logic [31:0] sum
);

	logic [45:0] xf;
	logic [29:0] x_s [scl_pkg::N_TERMS];
	logic [30:0] term_s [scl_pkg::N_TERMS+1];
	logic [31:0] sum_s [scl_pkg::N_TERMS+1];

	assign xf = 46'(uf) * 46'(scl_pkg::LN2_Q30);

	always_ff @(posedge clk) begin
		x_s[0]    <= xf[45:16];
		term_s[0] <= scl_pkg::Q30_ONE;
		sum_s[0]  <= 32'(scl_pkg::Q30_ONE);
	end

	for (genvar k = 1; k <= scl_pkg::N_TERMS; k++) begin : g_term
		localparam logic [32:0] RCP = 33'((64'd1 << 32) / k);
		localparam logic [3:0]  KV  = 4'(k);
		logic [60:0] p;
		logic [63:0] mq;
		logic [34:0] rem;
		logic [30:0] q;
		logic [30:0] v_a_s, v_b_s, q0_b_s;
		logic [29:0] x_a_s, x_b_s;
		logic [31:0] sum_a_s, sum_b_s;

		assign p   = 61'(term_s[k-1]) * 61'(x_s[k-1]);
		assign mq  = 64'(v_a_s) * 64'(RCP);
		assign rem = 35'(v_b_s) - 35'(q0_b_s) * 35'(KV);
		// The reciprocal estimate is at most one low.
		assign q   = (rem >= 35'(KV)) ? q0_b_s + 31'd1 : q0_b_s;

		always_ff @(posedge clk) begin
			v_a_s   <= p[60:30];
			x_a_s   <= x_s[k-1];
			sum_a_s <= sum_s[k-1];
			q0_b_s  <= mq[62:32];
			v_b_s   <= v_a_s;
			x_b_s   <= x_a_s;
			sum_b_s <= sum_a_s;
			term_s[k] <= q;
			sum_s[k]  <= sum_b_s + 32'(q);
		end

		if (k < scl_pkg::N_TERMS) begin : g_x
			always_ff @(posedge clk) begin
				x_s[k] <= x_b_s;
			end
		end else begin : g_xend
			logic [29:0] x_unused;
			assign x_unused = x_b_s;
		end
	end

	assign sum = sum_s[scl_pkg::N_TERMS];

endmodule

/* rtl/scl_channel.sv */
// One channel of the limiter: gain, log, decibel scaling, exp, knee and ceiling,
// sign restore and saturation, all as a fixed-depth pipeline.
// Depends on scl_pkg, scl_log2 and scl_exp2.
module scl_channel (
	input  logic                                   clk,
	input  scl_pkg::cfg_t                          cfg,
	input  logic signed [scl_pkg::SAMPLE_BITS-1:0] sample,
	output logic signed [scl_pkg::SAMPLE_BITS-1:0] result
);

	typedef struct packed {
		logic           neg;
		logic           zero;
		logic           over;
		scl_pkg::amag_t a;
	} side_t;

	scl_pkg::smag_t  sample_u, mag_c, mag_s1;
	logic            neg_s1, neg_s2;
	scl_pkg::gprod_t gprod;
	scl_pkg::amag_t  a_s2;
	side_t           side_s3;
	side_t           side_dl [scl_pkg::SIDE_DLY];

	logic [4:0]          lg_pos;
	logic [15:0]         lg_frac;
	logic signed [21:0]  lval;
	logic signed [42:0]  lk;
	logic signed [26:0]  m1_s21;
	logic signed [27:0]  overdb_s22;
	logic signed [47:0]  ts;
	logic signed [31:0]  t_s23;
	logic signed [63:0]  us;
	logic signed [33:0]  u_s24;
	logic signed [17:0]  ui_dl [scl_pkg::EXP_LAT];

	logic [31:0]         ex_sum;
	logic [51:0]         prod_s62;
	logic signed [17:0]  ui_s62;
	logic [51:0]         pr;
	logic [30:0]         r_c, r_s63;

	side_t               side_63;
	logic [31:0]         mm;
	logic [23:0]         m_s64;
	logic                neg_s64, zero_s64;
	logic [32:0]         mw, lim, mc;
	scl_pkg::smag_t      mcut, res_c;
	logic signed [scl_pkg::SAMPLE_BITS-1:0] res_s65;

	assign sample_u = scl_pkg::smag_t'(sample);
	assign mag_c    = sample[scl_pkg::SAMPLE_BITS-1] ? scl_pkg::smag_t'(~sample_u + 1'b1)
	                                                 : sample_u;
	assign gprod    = scl_pkg::gprod_t'(mag_s1) * scl_pkg::gprod_t'(cfg.gain);

	always_ff @(posedge clk) begin
		mag_s1  <= mag_c;
		neg_s1  <= sample[scl_pkg::SAMPLE_BITS-1];
		a_s2    <= scl_pkg::amag_t'(gprod >> scl_pkg::GAIN_SHIFT);
		neg_s2  <= neg_s1;
		side_s3 <= '{neg: neg_s2, zero: (a_s2 == '0),
		             over: (a_s2 > scl_pkg::amag_t'(cfg.knee)), a: a_s2};
		side_dl[0] <= side_s3;
		for (int i = 1; i < scl_pkg::SIDE_DLY; i++) side_dl[i] <= side_dl[i-1];
	end

	scl_log2 u_log (
		.clk  (clk),
		.a    (a_s2),
		.pos  (lg_pos),
		.frac (lg_frac)
	);

	assign lval = {6'(lg_pos) - 6'd23, lg_frac};
	assign lk   = 43'(lval) * 43'(scl_pkg::K1_Q16);
	assign ts   = 48'(overdb_s22) * $signed(48'(cfg.slope));
	assign us   = 64'(t_s23) * 64'(scl_pkg::LOG2E_Q30);

	always_ff @(posedge clk) begin
		m1_s21     <= 27'(lk >>> 16);
		overdb_s22 <= 28'(m1_s21) - (28'(cfg.cdb) <<< 8);
		t_s23      <= 32'(ts >>> 16);
		u_s24      <= 34'(us >>> 30);
		ui_dl[0]   <= u_s24[33:16];
		for (int i = 1; i < scl_pkg::EXP_LAT; i++) ui_dl[i] <= ui_dl[i-1];
	end

	scl_exp2 u_exp (
		.clk (clk),
		.uf  (u_s24[15:0]),
		.sum (ex_sum)
	);

	// The shift right is 30 minus the integer exponent; beyond the product width it gives zero.
	always_comb begin
		pr = '0;
		if (ui_s62 > 18'sd30) begin
			r_c = scl_pkg::R_CAP;
		end else if (ui_s62 < -18'sd21) begin
			r_c = '0;
		end else begin
			pr  = prod_s62 >> 6'(18'sd30 - ui_s62);
			r_c = (pr > 52'(scl_pkg::R_CAP)) ? scl_pkg::R_CAP : pr[30:0];
		end
	end

	assign side_63 = side_dl[scl_pkg::SIDE_DLY-1];
	assign mm      = side_63.over ? 32'(cfg.knee) + 32'(r_s63) : 32'(side_63.a);

	always_ff @(posedge clk) begin
		prod_s62 <= 52'(ex_sum) * 52'(scl_pkg::DB2LOG_Q23);
		ui_s62   <= ui_dl[scl_pkg::EXP_LAT-1];
		r_s63    <= r_c;
		m_s64    <= (mm > 32'(cfg.ceiling)) ? cfg.ceiling : mm[23:0];
		neg_s64  <= side_63.neg;
		zero_s64 <= side_63.zero;
	end

	// The negative side may reach the most negative code, the positive side stops one short.
	assign mw    = (33'(m_s64) << scl_pkg::UP) >> scl_pkg::DN;
	assign lim   = neg_s64 ? (33'd1 << (scl_pkg::SAMPLE_BITS - 1))
	                       : (33'd1 << (scl_pkg::SAMPLE_BITS - 1)) - 33'd1;
	assign mc    = (mw > lim) ? lim : mw;
	assign mcut  = mc[scl_pkg::SAMPLE_BITS-1:0];
	assign res_c = zero_s64 ? '0 : (neg_s64 ? scl_pkg::smag_t'(~mcut + 1'b1) : mcut);

	always_ff @(posedge clk) begin
		res_s65 <= $signed(res_c);
	end

	assign result = res_s65;

endmodule

/* rtl/stereo_soft_clip_limiter_top.sv */
// Stereo soft-clip limiter, top level: configuration registers, item valid line, two channels.
// done follows start through the item valid line; one stereo item per cycle.
// Depth is set by the 16 squaring stages of the log and the 12-term exp series.
// busy is always low; done marks each result for one cycle and cannot be held off.
// arst_n clears the valid line and loads the register defaults; payload is not reset.
// Depends on scl_pkg and scl_channel.
module stereo_soft_clip_limiter_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  scl_pkg::in_t                       sample_in,
	output logic                               done,
	output scl_pkg::out_t                      sample_out,
	input  logic                               cfg_we,
	input  logic [scl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scl_pkg::CFG_DATA_W-1:0]     cfg_data
);

	scl_pkg::cfg_t                cfg_q;
	logic [scl_pkg::CH_LAT-1:0]   vld_q;
	logic signed [scl_pkg::SAMPLE_BITS-1:0] left_res, right_res;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain    <= 24'd518287;
			cfg_q.ceiling <= 24'd8292584;
			cfg_q.cdb     <= -14'sd26;
			cfg_q.knee    <= 24'd6663306;
			cfg_q.slope   <= 19'd4629;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scl_pkg::CFG_GAIN:    cfg_q.gain    <= cfg_data;
				scl_pkg::CFG_CEILING: cfg_q.ceiling <= cfg_data;
				scl_pkg::CFG_CDB:     cfg_q.cdb     <= $signed(cfg_data[13:0]);
				scl_pkg::CFG_KNEE:    cfg_q.knee    <= cfg_data;
				scl_pkg::CFG_SLOPE:   cfg_q.slope   <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[scl_pkg::CH_LAT-2:0], start & ~busy};
		end
	end

	scl_channel u_left (
		.clk    (clk),
		.cfg    (cfg_q),
		.sample (sample_in.left_in),
		.result (left_res)
	);

	scl_channel u_right (
		.clk    (clk),
		.cfg    (cfg_q),
		.sample (sample_in.right_in),
		.result (right_res)
	);

	assign done = vld_q[scl_pkg::CH_LAT-1];

	always_comb begin
		sample_out.left_out  = left_res;
		sample_out.right_out = right_res;
	end

endmodule

/* rtl/scl_checker.sv */
// Port-level checks for the stereo soft-clip limiter and the bind that attaches them.
// Depends on scl_pkg and stereo_soft_clip_limiter_top.
module scl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input scl_pkg::in_t  sample_in,
	input logic          done,
	input scl_pkg::out_t sample_out
);

	// Every result comes from an item taken exactly one pipeline depth earlier.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, scl_pkg::CH_LAT))
		else $error("result without a matching item");

	a_left_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && sample_in.left_in == '0, scl_pkg::CH_LAT)
		|-> sample_out.left_out == '0)
		else $error("zero left item gave a nonzero result");

	a_left_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && !sample_in.left_in[scl_pkg::SAMPLE_BITS-1],
		              scl_pkg::CH_LAT)
		|-> !sample_out.left_out[scl_pkg::SAMPLE_BITS-1])
		else $error("nonnegative left item gave a negative result");

	a_right_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && !sample_in.right_in[scl_pkg::SAMPLE_BITS-1],
		              scl_pkg::CH_LAT)
		|-> !sample_out.right_out[scl_pkg::SAMPLE_BITS-1])
		else $error("nonnegative right item gave a negative result");

endmodule

bind stereo_soft_clip_limiter_top scl_checker u_scl_checker (.*);
